// ----- src/scfl_pkg.sv -----
package scfl_pkg;

  // Fixed byte values on the line.
  localparam logic [7:0] SYNC_BYTE = 8'h36;
  localparam logic [7:0] BROADCAST = 8'hFF;
  localparam logic [7:0] ZERO_BYTE = 8'h00;

  // Default frame length in bytes (legal range 5 to 8).
  localparam int FRAME_LEN_DEF = 7;

  // Positions within a frame.
  localparam logic [2:0] POS_SYNC   = 3'd0;
  localparam logic [2:0] POS_SRC    = 3'd1;
  localparam logic [2:0] POS_TGT    = 3'd2;
  localparam logic [2:0] POS_CMD    = 3'd3;
  localparam logic [2:0] POS_SUM    = 3'd4;

  // Configuration register map.
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_OWN_ID     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INTER_CALL = 2'd1;

  typedef enum logic [1:0] {
    OP_RX_BYTE = 2'd0,
    OP_TIMEOUT = 2'd1,
    OP_SEND    = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_ACCEPTED   = 2'd0,
    ST_BAD_SUM    = 2'd1,
    ST_OWN_ECHO   = 2'd2,
    ST_NOT_ADDRSD = 2'd3
  } status_t;

  typedef enum logic {
    KIND_TX     = 1'b0,
    KIND_REPORT = 1'b1
  } kind_t;

endpackage

// ----- src/sync_checksum_frame_link.sv -----
// Link layer for short fixed-length byte frames: sync 0x36, source, target,
// command, checksum (sum of the three preceding bytes modulo 256) and 0xFF
// trailer bytes up to FRAME_LEN.
// Input channel (in_valid / in_stall): each request is one operation: a
// received line byte, a reception timeout, or a request to send a frame.
// Result channel (out_valid / out_stall): transmit bytes (kind 0), in line
// order, and received-frame reports (kind 1); last marks the final result of
// the request that caused them.
// Configuration channel (cfg_valid / cfg_ready): own station number and the
// intercom call code; cfg_ready is always high, writes are to go in while
// idle, which the block does not enforce. A request waits in an input
// register until no frame is being sent and a result slot is free or not
// needed. Byte and timeout requests are taken one per cycle under those
// conditions; a send emits FRAME_LEN bytes, one per cycle while out_stall is
// low, and a request behind it is stalled until the last byte is in the
// result register. Reset clears the receiver to waiting for sync, the
// remembered sent command to zero and both configuration registers to zero.
// When the receiver stalls, the result register holds its contents and a
// request needing a result slot holds in_stall high until a slot frees.
module sync_checksum_frame_link #(
  parameter int FRAME_LEN = scfl_pkg::FRAME_LEN_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,

  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [1:0]                     in_operation,
  input  logic [7:0]                     in_rx_byte,
  input  logic [7:0]                     in_send_target,
  input  logic [7:0]                     in_send_command,

  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           out_kind,
  output logic [1:0]                     out_status,
  output logic [7:0]                     out_source_id,
  output logic [7:0]                     out_target_id,
  output logic [7:0]                     out_command,
  output logic [7:0]                     out_tx_byte,
  output logic                           out_last,

  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [scfl_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                     cfg_data
);
  import scfl_pkg::*;

  localparam logic [2:0] LAST_POS = 3'(FRAME_LEN - 1);
  localparam logic [3:0] LEN4     = 4'(FRAME_LEN);

  // Configuration registers.
  logic [2:0] own_id_r;
  logic [7:0] inter_call_r;

  // Input register.
  logic       ir_valid_r;
  logic [1:0] ir_op_r;
  logic [7:0] ir_rx_r;
  logic [7:0] ir_tgt_r;
  logic [7:0] ir_cmd_r;

  // Receiver and echo state.
  logic       receiving_r, receiving_nxt;
  logic [2:0] byte_idx_r, byte_idx_nxt;
  logic [7:0] frame_r [4];
  logic [7:0] frame_nxt [4];
  logic [7:0] last_cmd_r, last_cmd_nxt;

  // Transmit sequencer.
  logic       tx_busy_r;
  logic [2:0] tx_idx_r;
  logic [7:0] tx_src_r;
  logic [7:0] tx_tgt_r;
  logic [7:0] tx_cmd_r;
  logic [7:0] tx_sum_r;
  logic [7:0] tx_byte_sel;

  // Result register.
  logic       out_valid_r;
  logic       out_kind_r;
  logic [1:0] out_status_r;
  logic [7:0] out_src_r;
  logic [7:0] out_tgt_r;
  logic [7:0] out_cmd_r;
  logic [7:0] out_tx_r;
  logic       out_last_r;

  logic       slot_free;
  logic       proc_go;
  logic       produces;
  logic       frame_done;
  status_t    status_c;
  logic [7:0] sum_c;
  logic [7:0] own_addr;
  logic [7:0] send_sum;
  logic [1:0] store_idx;

  assign cfg_ready = 1'b1;
  assign own_addr  = {5'd0, own_id_r} + 8'd1;
  assign send_sum  = own_addr + ir_tgt_r + ir_cmd_r;
  assign store_idx = 2'(byte_idx_r - 3'd1);

  // The result register can take a new result when it is empty or being
  // drained in this cycle.
  assign slot_free = !out_valid_r || !out_stall;

  // Receiver: next state of the frame parser for the request held in the
  // input register. Applied only when the request is processed.
  always_comb begin
    receiving_nxt = receiving_r;
    byte_idx_nxt  = byte_idx_r;
    last_cmd_nxt  = last_cmd_r;
    frame_done    = 1'b0;
    produces      = 1'b0;
    for (int i = 0; i < 4; i++) begin
      frame_nxt[i] = frame_r[i];
    end
    case (op_t'(ir_op_r))
      OP_RX_BYTE: begin
        if (!receiving_r) begin
          if (ir_rx_r == SYNC_BYTE) begin
            receiving_nxt = 1'b1;
            byte_idx_nxt  = POS_SRC;
          end
        end else if (ir_rx_r == SYNC_BYTE) begin
          byte_idx_nxt = POS_SRC;
        end else if (ir_rx_r != ZERO_BYTE) begin
          if (byte_idx_r >= POS_SRC && byte_idx_r <= POS_SUM) begin
            frame_nxt[store_idx] = ir_rx_r;
          end
          if (({1'b0, byte_idx_r} + 4'd1) >= LEN4) begin
            frame_done    = 1'b1;
            produces      = 1'b1;
            receiving_nxt = 1'b0;
            byte_idx_nxt  = POS_SYNC;
          end else begin
            byte_idx_nxt = byte_idx_r + 3'd1;
          end
        end
      end
      OP_TIMEOUT: begin
        receiving_nxt = 1'b0;
        byte_idx_nxt  = POS_SYNC;
      end
      OP_SEND: begin
        produces      = 1'b1;
        last_cmd_nxt  = ir_cmd_r;
        receiving_nxt = 1'b0;
        byte_idx_nxt  = POS_SYNC;
      end
      default: begin
      end
    endcase

    // Frame verdict, taken from the store including the byte just written.
    sum_c    = frame_nxt[0] + frame_nxt[1] + frame_nxt[2];
    status_c = ST_NOT_ADDRSD;
    if (frame_nxt[3] != sum_c) begin
      status_c = ST_BAD_SUM;
    end else if (frame_nxt[2] == last_cmd_r) begin
      status_c = ST_OWN_ECHO;
      if (frame_done) begin
        last_cmd_nxt = ZERO_BYTE;
      end
    end else if (frame_nxt[1] == BROADCAST || frame_nxt[1] == own_addr ||
                 frame_nxt[2] == inter_call_r) begin
      status_c = ST_ACCEPTED;
    end
  end

  // A request without results needs no result slot; nothing is processed
  // while a frame is still being transmitted.
  assign proc_go  = ir_valid_r && !tx_busy_r && (slot_free || !produces);
  assign in_stall = ir_valid_r && !proc_go;

  always_comb begin
    case (tx_idx_r)
      POS_SYNC: tx_byte_sel = SYNC_BYTE;
      POS_SRC:  tx_byte_sel = tx_src_r;
      POS_TGT:  tx_byte_sel = tx_tgt_r;
      POS_CMD:  tx_byte_sel = tx_cmd_r;
      POS_SUM:  tx_byte_sel = tx_sum_r;
      default:  tx_byte_sel = BROADCAST;
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_id_r     <= 3'd0;
      inter_call_r <= 8'd0;
      ir_valid_r   <= 1'b0;
      receiving_r  <= 1'b0;
      byte_idx_r   <= POS_SYNC;
      last_cmd_r   <= 8'd0;
      tx_busy_r    <= 1'b0;
      tx_idx_r     <= POS_SYNC;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_OWN_ID:     own_id_r     <= cfg_data[2:0];
          CFG_INTER_CALL: inter_call_r <= cfg_data;
          default: begin
          end
        endcase
      end

      if (in_valid && !in_stall) begin
        ir_valid_r <= 1'b1;
      end else if (proc_go) begin
        ir_valid_r <= 1'b0;
      end

      if (proc_go) begin
        receiving_r <= receiving_nxt;
        byte_idx_r  <= byte_idx_nxt;
        last_cmd_r  <= last_cmd_nxt;
      end

      if (tx_busy_r && slot_free) begin
        tx_idx_r <= tx_idx_r + 3'd1;
        if (tx_idx_r == LAST_POS) begin
          tx_busy_r <= 1'b0;
        end
      end else if (proc_go && op_t'(ir_op_r) == OP_SEND) begin
        tx_busy_r <= 1'b1;
        tx_idx_r  <= POS_SRC;
      end

      if ((tx_busy_r && slot_free) || (proc_go && produces)) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      ir_op_r  <= in_operation;
      ir_rx_r  <= in_rx_byte;
      ir_tgt_r <= in_send_target;
      ir_cmd_r <= in_send_command;
    end

    if (proc_go) begin
      for (int i = 0; i < 4; i++) begin
        frame_r[i] <= frame_nxt[i];
      end
    end

    if (proc_go && op_t'(ir_op_r) == OP_SEND) begin
      tx_src_r <= own_addr;
      tx_tgt_r <= ir_tgt_r;
      tx_cmd_r <= ir_cmd_r;
      tx_sum_r <= send_sum;
    end

    if (tx_busy_r && slot_free) begin
      out_kind_r   <= KIND_TX;
      out_status_r <= ST_ACCEPTED;
      out_src_r    <= 8'd0;
      out_tgt_r    <= 8'd0;
      out_cmd_r    <= 8'd0;
      out_tx_r     <= tx_byte_sel;
      out_last_r   <= (tx_idx_r == LAST_POS);
    end else if (proc_go && produces) begin
      if (frame_done) begin
        out_kind_r   <= KIND_REPORT;
        out_status_r <= status_c;
        out_src_r    <= frame_nxt[0];
        out_tgt_r    <= frame_nxt[1];
        out_cmd_r    <= frame_nxt[2];
        out_tx_r     <= 8'd0;
        out_last_r   <= 1'b1;
      end else begin
        // First byte of a send: the sync byte.
        out_kind_r   <= KIND_TX;
        out_status_r <= ST_ACCEPTED;
        out_src_r    <= 8'd0;
        out_tgt_r    <= 8'd0;
        out_cmd_r    <= 8'd0;
        out_tx_r     <= SYNC_BYTE;
        out_last_r   <= 1'b0;
      end
    end
  end

  assign out_valid     = out_valid_r;
  assign out_kind      = out_kind_r;
  assign out_status    = out_status_r;
  assign out_source_id = out_src_r;
  assign out_target_id = out_tgt_r;
  assign out_command   = out_cmd_r;
  assign out_tx_byte   = out_tx_r;
  assign out_last      = out_last_r;

endmodule

// ----- tb/sv/sync_checksum_frame_link_tb.sv -----
`timescale 1ns / 100ps

module sync_checksum_frame_link_tb;
  import scfl_pkg::*;

  // The reserved operation code has no member in op_t. The block must drop it
  // without any result.
  localparam logic [1:0] OP_RESERVED = 2'd3;

  localparam int FRAME_BYTES = FRAME_LEN_DEF;
  // Idle cycles allowed after the last expected result. This covers requests
  // that produce nothing but may still sit in the input register.
  localparam int SETTLE_CYCLES = 8;
  // The slowest correct run is roughly 460 requests, each making seven
  // results, each held by the longest stall the receiver makes. The limit
  // is several times that.
  localparam int CYCLE_LIMIT = 600000;
  localparam int PHASE_REQUESTS = 90;

  logic       clk;
  logic       rst_n;

  logic       in_valid;
  logic       in_stall;
  logic [1:0] in_operation;
  logic [7:0] in_rx_byte;
  logic [7:0] in_send_target;
  logic [7:0] in_send_command;

  logic       out_valid;
  logic       out_stall;
  logic       out_kind;
  logic [1:0] out_status;
  logic [7:0] out_source_id;
  logic [7:0] out_target_id;
  logic [7:0] out_command;
  logic [7:0] out_tx_byte;
  logic       out_last;

  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [7:0]           cfg_data;

  sync_checksum_frame_link dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_operation    (in_operation),
    .in_rx_byte      (in_rx_byte),
    .in_send_target  (in_send_target),
    .in_send_command (in_send_command),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_kind        (out_kind),
    .out_status      (out_status),
    .out_source_id   (out_source_id),
    .out_target_id   (out_target_id),
    .out_command     (out_command),
    .out_tx_byte     (out_tx_byte),
    .out_last        (out_last),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  // One result as the block should present it on the result channel.
  typedef struct {
    kind_t      kind;
    status_t    status;
    logic [7:0] source_id;
    logic [7:0] target_id;
    logic [7:0] command;
    logic [7:0] tx_byte;
    logic       last;
  } link_result_t;

  // Results still owed by the block, oldest first.
  link_result_t link_results_due[$];

  // Our own copy of the link state and of the two registers. It is updated at
  // the clock edge at which each request or register write is accepted.
  logic       rx_active;
  logic [2:0] rx_pos;
  logic [7:0] rx_frame [4];
  logic [7:0] last_sent_cmd;
  logic [2:0] station_id;
  logic [7:0] intercom_code;

  int  mismatches;
  int  accepted_requests;
  int  cycle_count;
  // When set, the sender issues requests back to back with no idle gaps.
  bit  steady_sender;

  // ---------------------------------------------------------------------
  // Clock, watchdog and the receiver's stall pattern.
  // ---------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // If the run hangs, for example because a request is never accepted or an
  // expected result never appears, this ends it.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // The receiver alternates between stretches with no stalls at all, short
  // stalls and the occasional long one. Over a long run this lands stalls on
  // every byte position of a transmitted frame and on every report.
  initial begin : drive_out_stall
    int stall_left;
    int free_left;
    int pick;
    stall_left = 0;
    free_left = 0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (free_left > 0) begin
        free_left--;
        out_stall <= 1'b0;
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
          free_left = $urandom_range(1, 40);
        end else if (pick < 90) begin
          stall_left = $urandom_range(1, 3);
        end else begin
          stall_left = $urandom_range(8, 30);
        end
        out_stall <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Prediction.
  // ---------------------------------------------------------------------
  // Our own bus address is the station number plus one.
  function automatic logic [7:0] station_addr();
    return {5'd0, station_id} + 8'd1;
  endfunction

  function automatic void owe_result(kind_t kind, status_t status, logic [7:0] src,
                                     logic [7:0] tgt, logic [7:0] cmd,
                                     logic [7:0] txb, logic last);
    link_result_t r;
    r.kind      = kind;
    r.status    = status;
    r.source_id = src;
    r.target_id = tgt;
    r.command   = cmd;
    r.tx_byte   = txb;
    r.last      = last;
    link_results_due.push_back(r);
  endfunction

  // Work out what one accepted request does to the link, and queue the
  // results that it causes.
  function automatic void predict_link_step(logic [1:0] op, logic [7:0] rx,
                                            logic [7:0] tgt, logic [7:0] cmd);
    logic [7:0] sum;
    logic [7:0] src;
    status_t    verdict;
    case (op)
      OP_RX_BYTE: begin
        if (!rx_active) begin
          // While waiting for sync, every other byte is thrown away.
          if (rx == SYNC_BYTE) begin
            rx_active = 1'b1;
            rx_pos = POS_SRC;
          end
        end else if (rx == SYNC_BYTE) begin
          rx_pos = POS_SRC;
        end else if (rx != ZERO_BYTE) begin
          if (rx_pos >= POS_SRC && rx_pos <= POS_SUM)
            rx_frame[rx_pos - 3'd1] = rx;
          if (int'(rx_pos) + 1 >= FRAME_BYTES) begin
            // The frame is complete. Its trailer bytes are counted; apart from
            // sync and zero bytes, their values are never checked.
            sum = rx_frame[0] + rx_frame[1] + rx_frame[2];
            if (rx_frame[3] != sum) begin
              verdict = ST_BAD_SUM;
            end else if (rx_frame[2] == last_sent_cmd) begin
              verdict = ST_OWN_ECHO;
              last_sent_cmd = 8'd0;
            end else if (rx_frame[1] == BROADCAST || rx_frame[1] == station_addr() ||
                         rx_frame[2] == intercom_code) begin
              verdict = ST_ACCEPTED;
            end else begin
              verdict = ST_NOT_ADDRSD;
            end
            owe_result(KIND_REPORT, verdict, rx_frame[0], rx_frame[1], rx_frame[2],
                       8'd0, 1'b1);
            rx_active = 1'b0;
            rx_pos = POS_SYNC;
          end else begin
            rx_pos = rx_pos + 3'd1;
          end
        end
      end
      OP_TIMEOUT: begin
        rx_active = 1'b0;
        rx_pos = POS_SYNC;
      end
      OP_SEND: begin
        src = station_addr();
        sum = src + tgt + cmd;
        owe_result(KIND_TX, ST_ACCEPTED, 8'd0, 8'd0, 8'd0, SYNC_BYTE, 1'b0);
        owe_result(KIND_TX, ST_ACCEPTED, 8'd0, 8'd0, 8'd0, src, 1'b0);
        owe_result(KIND_TX, ST_ACCEPTED, 8'd0, 8'd0, 8'd0, tgt, 1'b0);
        owe_result(KIND_TX, ST_ACCEPTED, 8'd0, 8'd0, 8'd0, cmd, 1'b0);
        owe_result(KIND_TX, ST_ACCEPTED, 8'd0, 8'd0, 8'd0, sum, 1'b0);
        for (int k = 5; k < FRAME_BYTES; k++)
          owe_result(KIND_TX, ST_ACCEPTED, 8'd0, 8'd0, 8'd0, BROADCAST,
                     k == FRAME_BYTES - 1);
        // A send aborts any frame that is being received.
        last_sent_cmd = cmd;
        rx_active = 1'b0;
        rx_pos = POS_SYNC;
      end
      default: begin
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------
  // Result checking.
  // ---------------------------------------------------------------------
  // Each result is taken at the edge at which out_valid is high and out_stall
  // is low. It is compared with the oldest result still owed.
  always @(posedge clk) begin : check_results
    link_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (link_results_due.size() == 0) begin
        if (mismatches < 10)
          $display("%0t: unexpected result kind %0d status %0d src %02h tgt %02h %s",
                   $time, out_kind, out_status, out_source_id, out_target_id,
                   $sformatf("cmd %02h tx %02h last %0d",
                             out_command, out_tx_byte, out_last));
        mismatches++;
      end else begin
        want = link_results_due.pop_front();
        if (out_kind !== want.kind || out_status !== want.status ||
            out_source_id !== want.source_id || out_target_id !== want.target_id ||
            out_command !== want.command || out_tx_byte !== want.tx_byte ||
            out_last !== want.last) begin
          if (mismatches < 10) begin
            $display("%0t: result mismatch", $time);
            $display("  expected kind %0d status %0d src %02h tgt %02h cmd %02h tx %02h last %0d",
                     want.kind, want.status, want.source_id, want.target_id,
                     want.command, want.tx_byte, want.last);
            $display("  actual   kind %0d status %0d src %02h tgt %02h cmd %02h tx %02h last %0d",
                     out_kind, out_status, out_source_id, out_target_id,
                     out_command, out_tx_byte, out_last);
          end
          mismatches++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Request and register drivers.
  // ---------------------------------------------------------------------
  // Most requests follow one another directly. Some come after a short gap
  // and a few after a long one.
  function automatic int pick_gap();
    int pick;
    pick = $urandom_range(0, 99);
    if (steady_sender || pick < 60)
      return 0;
    if (pick < 92)
      return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Present one request and hold it until the block accepts it. in_valid is
  // left high afterwards, so that a request that follows directly does not
  // lower and raise it in the same time step. Any task that pauses the
  // sender lowers it first.
  task automatic send_request(logic [1:0] op, logic [7:0] rx, logic [7:0] tgt,
                              logic [7:0] cmd);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_operation    <= op;
    in_rx_byte      <= rx;
    in_send_target  <= tgt;
    in_send_command <= cmd;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_link_step(op, rx, tgt, cmd);
    if (op != OP_RESERVED)
      accepted_requests++;
  endtask

  // The fields that an operation does not use get random values, so that
  // the block is seen to ignore them.
  task automatic send_byte(logic [7:0] b);
    send_request(OP_RX_BYTE, b, 8'($urandom), 8'($urandom));
  endtask

  task automatic send_timeout();
    send_request(OP_TIMEOUT, 8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  task automatic send_transmit(logic [7:0] tgt, logic [7:0] cmd);
    send_request(OP_SEND, 8'($urandom), tgt, cmd);
  endtask

  // Feed a whole frame on the line. When sum_ok is clear, the checksum is
  // off by one.
  task automatic send_line_frame(logic [7:0] src, logic [7:0] tgt, logic [7:0] cmd,
                                 logic sum_ok, logic [7:0] trailer);
    logic [7:0] sum;
    sum = src + tgt + cmd;
    if (!sum_ok)
      sum = sum + 8'd1;
    send_byte(SYNC_BYTE);
    send_byte(src);
    send_byte(tgt);
    send_byte(cmd);
    send_byte(sum);
    for (int k = 5; k < FRAME_BYTES; k++)
      send_byte(trailer);
  endtask

  // Stop sending until every owed result has arrived. Then wait a little
  // longer for requests that produce nothing.
  task automatic wait_results_drained();
    in_valid <= 1'b0;
    while (link_results_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write both registers back to back. This is only called while the link is
  // drained.
  task automatic write_config(logic [2:0] own, logic [7:0] intercom);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_OWN_ID;
    cfg_data  <= {5'd0, own};
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    station_id = own;
    cfg_index <= CFG_INTER_CALL;
    cfg_data  <= intercom;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    intercom_code = intercom;
    cfg_valid <= 1'b0;
  endtask

  // ---------------------------------------------------------------------
  // Random traffic.
  // ---------------------------------------------------------------------
  // A single stray request: a timeout, a reserved operation, a random line
  // byte or a send.
  task automatic send_noise();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 30)
      send_timeout();
    else if (pick < 45)
      send_request(OP_RESERVED, 8'($urandom), 8'($urandom), 8'($urandom));
    else if (pick < 75)
      send_byte(8'($urandom));
    else
      send_transmit(($urandom_range(0, 1) != 0) ? BROADCAST : 8'($urandom),
                    8'($urandom));
  endtask

  // A frame whose content is random but is steered towards the interesting
  // outcomes: broadcast, our own address, an intercom call, our own echo and
  // a bad checksum. Zero bytes are scattered through it. Now and then the
  // frame is cut short and followed by a stray request.
  task automatic send_random_frame();
    logic [7:0] line_bytes [FRAME_BYTES];
    logic [7:0] src;
    logic [7:0] tgt;
    logic [7:0] cmd;
    int         pick;
    int         cut;
    src = 8'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 30)
      tgt = BROADCAST;
    else if (pick < 55)
      tgt = station_addr();
    else
      tgt = 8'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 15)
      cmd = last_sent_cmd;
    else if (pick < 35)
      cmd = intercom_code;
    else
      cmd = 8'($urandom);
    line_bytes[0] = SYNC_BYTE;
    line_bytes[1] = src;
    line_bytes[2] = tgt;
    line_bytes[3] = cmd;
    line_bytes[4] = src + tgt + cmd;
    if ($urandom_range(0, 99) < 15)
      line_bytes[4] = line_bytes[4] ^ 8'($urandom_range(1, 255));
    for (int k = 5; k < FRAME_BYTES; k++)
      line_bytes[k] = 8'($urandom);
    cut = FRAME_BYTES;
    if ($urandom_range(0, 99) < 10)
      cut = $urandom_range(1, FRAME_BYTES - 1);
    for (int k = 0; k < cut; k++) begin
      if (k > 0 && $urandom_range(0, 99) < 8)
        send_byte(ZERO_BYTE);
      send_byte(line_bytes[k]);
    end
    if (cut < FRAME_BYTES)
      send_noise();
  endtask

  // ---------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------
  // Requests that must never produce a result: a timeout while idle, the
  // reserved operation, and line bytes other than sync while waiting.
  task automatic test_idle_requests();
    send_timeout();
    send_request(OP_RESERVED, 8'hFF, 8'hFF, 8'hFF);
    send_byte(ZERO_BYTE);
    send_byte(8'hFF);
    send_byte(8'hAA);
  endtask

  // Reception with the reset settings. The frame carries a zero byte that
  // must be skipped and a second sync that restarts it. After that, a
  // partial frame is ended by a timeout, and the byte that follows falls
  // into the waiting state.
  task automatic test_frame_reception();
    send_byte(SYNC_BYTE);
    send_byte(ZERO_BYTE);
    send_byte(8'h01);
    send_byte(SYNC_BYTE);
    send_byte(8'h02);
    send_byte(8'h01);
    send_byte(8'h10);
    send_byte(8'h13);
    send_byte(ZERO_BYTE);
    send_byte(8'h5A);
    send_byte(8'hFF);
    send_byte(SYNC_BYTE);
    send_byte(8'h02);
    send_timeout();
    send_byte(8'h07);
  endtask

  // A send aborts a partial frame and is remembered. The echo of the last
  // send is reported as our own echo, which clears the remembered command,
  // then the same command with a bad checksum is reported as such.
  task automatic test_send_and_echo();
    send_byte(SYNC_BYTE);
    send_byte(8'h05);
    send_transmit(8'h00, 8'hFF);
    send_transmit(BROADCAST, 8'h20);
    send_line_frame(8'h01, BROADCAST, 8'h20, 1'b1, 8'h77);
    send_line_frame(8'h01, BROADCAST, 8'h20, 1'b0, 8'h77);
  endtask

  // With the highest station number, the bus address is 8. A frame is
  // addressed through that address or through the intercom code. Without
  // either, it is reported as not addressed.
  task automatic test_addressing();
    wait_results_drained();
    write_config(3'd7, 8'h5A);
    send_line_frame(8'h03, 8'h08, 8'h11, 1'b1, BROADCAST);
    send_line_frame(8'h03, 8'h09, 8'h5A, 1'b1, BROADCAST);
    send_line_frame(8'h03, 8'h09, 8'h11, 1'b1, BROADCAST);
  endtask

  // Random traffic under several register settings, both extremes among
  // them. One phase runs the sender with no random gaps. Now and then the
  // sender waits until every owed result has arrived.
  task automatic test_random_traffic();
    int start;
    int pick;
    for (int phase = 0; phase < 4; phase++) begin
      wait_results_drained();
      case (phase)
        0:       write_config(3'd0, 8'h00);
        1:       write_config(3'd7, 8'hFF);
        default: write_config(3'($urandom), 8'($urandom));
      endcase
      steady_sender = (phase == 2);
      start = accepted_requests;
      while (accepted_requests - start < PHASE_REQUESTS) begin
        pick = $urandom_range(0, 99);
        if (pick < 72)
          send_random_frame();
        else if (pick < 84)
          send_transmit(($urandom_range(0, 2) == 0) ? BROADCAST : 8'($urandom),
                        ($urandom_range(0, 3) == 0) ? intercom_code : 8'($urandom));
        else if (pick < 97)
          send_noise();
        else
          wait_results_drained();
      end
    end
    steady_sender = 1'b0;
  endtask

  // ---------------------------------------------------------------------
  // Sequence.
  // ---------------------------------------------------------------------
  initial begin
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_operation    = OP_RX_BYTE;
    in_rx_byte      = 8'd0;
    in_send_target  = 8'd0;
    in_send_command = 8'd0;
    cfg_valid       = 1'b0;
    cfg_index       = CFG_OWN_ID;
    cfg_data        = 8'd0;

    rx_active         = 1'b0;
    rx_pos            = POS_SYNC;
    last_sent_cmd     = 8'd0;
    station_id        = 3'd0;
    intercom_code     = 8'd0;
    mismatches        = 0;
    accepted_requests = 0;
    cycle_count       = 0;
    steady_sender     = 1'b0;
    for (int k = 0; k < 4; k++)
      rx_frame[k] = 8'd0;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_idle_requests();
    test_frame_reception();
    test_send_and_echo();
    test_addressing();
    test_random_traffic();

    wait_results_drained();
    if (mismatches == 0 && link_results_due.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
